### rtl/cs4_pkg.sv
// Shared constants for the four-symbol chi-square pipeline.
// No dependencies; every other file refers to these by scoped name.
package cs4_pkg;

    localparam int LANES      = 4;
    localparam int FRAC_BITS  = 8;
    localparam int COUNT_BITS = 16;
    localparam int IN_W       = 16;

    // Output field widths are fixed by the interface.
    localparam int OUT_TOT_W   = 18;
    localparam int OUT_PART_W  = 28;
    localparam int OUT_SHARE_W = 7;
    localparam int OUT_DEG_W   = 2;

    // Internal widths follow from the count width and fraction bits.
    localparam int TOTAL_W = COUNT_BITS + 2;
    localparam int DIFF_W  = TOTAL_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DEN_W   = TOTAL_W + 2;
    localparam int PDIV_W  = SQ_W + FRAC_BITS + 1;
    localparam int PQ_W    = TOTAL_W + 2 + FRAC_BITS;
    localparam int SUM_W   = PQ_W + 2;

    localparam int SHARE_SCALE = 200;
    localparam int SN_W        = PQ_W + 9;
    localparam int SHDEN_W     = SUM_W + 1;
    localparam int SHQ_W       = 7;

    // Pipeline depth: four front stages, one stage per partial quotient bit,
    // sum and share-numerator stages, then one stage per share quotient bit.
    localparam int FRONT = 4;
    localparam int M1    = FRONT + PQ_W;
    localparam int LAT   = M1 + 2 + SHQ_W;
    localparam int MIDD  = SHQ_W + 2;

    localparam logic [OUT_DEG_W-1:0] DEG_NONE       = 2'd0;
    localparam logic [OUT_DEG_W-1:0] DEG_ZERO_TOTAL = 2'd1;
    localparam logic [OUT_DEG_W-1:0] DEG_ZERO_CHI   = 2'd2;

endpackage

### rtl/cs4_part_div.sv
// Pipelined restoring divider for one partial chi-square term.
// One quotient bit per register stage; uses cs4_pkg widths.
module cs4_part_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [cs4_pkg::PDIV_W-1:0]  dividend,
    input  logic [cs4_pkg::DEN_W-1:0]   divisor,
    output logic [cs4_pkg::PQ_W-1:0]    quotient
);

    logic [cs4_pkg::DEN_W-1:0] rem_reg [cs4_pkg::PQ_W];
    logic [cs4_pkg::PQ_W-1:0]  dq_reg  [cs4_pkg::PQ_W];
    logic [cs4_pkg::DEN_W-1:0] dv_reg  [cs4_pkg::PQ_W];

    genvar k;
    for (k = 0; k < cs4_pkg::PQ_W; k++)
    begin : g_step
        logic [cs4_pkg::DEN_W-1:0] rem_in;
        logic [cs4_pkg::DEN_W-1:0] dv_in;
        logic [cs4_pkg::PQ_W-1:0]  dq_in;
        logic [cs4_pkg::DEN_W:0]   trial;
        logic                      ge;

        if (k == 0)
        begin : g_first
            // The quotient fits PQ_W bits, so the upper dividend part is below the divisor.
            assign rem_in = cs4_pkg::DEN_W'(dividend[cs4_pkg::PDIV_W-1:cs4_pkg::PQ_W]);
            assign dq_in  = dividend[cs4_pkg::PQ_W-1:0];
            assign dv_in  = divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign dv_in  = dv_reg[k-1];
        end

        assign trial = {rem_in, dq_in[cs4_pkg::PQ_W-1]};
        assign ge    = trial >= {1'b0, dv_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? cs4_pkg::DEN_W'(trial - {1'b0, dv_in})
                                 : cs4_pkg::DEN_W'(trial);
                dq_reg[k]  <= {dq_in[cs4_pkg::PQ_W-2:0], ge};
                dv_reg[k]  <= dv_in;
            end
        end
    end

    assign quotient = dq_reg[cs4_pkg::PQ_W-1];

endmodule

### rtl/cs4_share_div.sv
// Pipelined restoring divider for one percent share.
// One quotient bit per register stage; uses cs4_pkg widths.
module cs4_share_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [cs4_pkg::SN_W-1:0]     dividend,
    input  logic [cs4_pkg::SHDEN_W-1:0]  divisor,
    output logic [cs4_pkg::SHQ_W-1:0]    quotient
);

    logic [cs4_pkg::SHDEN_W-1:0] rem_reg [cs4_pkg::SHQ_W];
    logic [cs4_pkg::SHQ_W-1:0]   dq_reg  [cs4_pkg::SHQ_W];
    logic [cs4_pkg::SHDEN_W-1:0] dv_reg  [cs4_pkg::SHQ_W];

    genvar k;
    for (k = 0; k < cs4_pkg::SHQ_W; k++)
    begin : g_step
        logic [cs4_pkg::SHDEN_W-1:0] rem_in;
        logic [cs4_pkg::SHDEN_W-1:0] dv_in;
        logic [cs4_pkg::SHQ_W-1:0]   dq_in;
        logic [cs4_pkg::SHDEN_W:0]   trial;
        logic                        ge;

        if (k == 0)
        begin : g_first
            // A share never reaches 128, so the upper part starts below the divisor.
            assign rem_in = cs4_pkg::SHDEN_W'(dividend[cs4_pkg::SN_W-1:cs4_pkg::SHQ_W]);
            assign dq_in  = dividend[cs4_pkg::SHQ_W-1:0];
            assign dv_in  = divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign dv_in  = dv_reg[k-1];
        end

        assign trial = {rem_in, dq_in[cs4_pkg::SHQ_W-1]};
        assign ge    = trial >= {1'b0, dv_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? cs4_pkg::SHDEN_W'(trial - {1'b0, dv_in})
                                 : cs4_pkg::SHDEN_W'(trial);
                dq_reg[k]  <= {dq_in[cs4_pkg::SHQ_W-2:0], ge};
                dv_reg[k]  <= dv_in;
            end
        end
    end

    assign quotient = dq_reg[cs4_pkg::SHQ_W-1];

endmodule

### rtl/chi_square_uniform_four_core.sv
// Chi-square test of four symbol counts against a uniform expectation.
// Depends on cs4_pkg, cs4_part_div and cs4_share_div.
//
// Usage: a request on the input channel (in_valid, in_stall) carries four
// counts; each request yields exactly one result on the output channel
// (out_valid, out_stall). A request is taken at a clock edge where valid is
// high and stall is low.
// The pipeline has total, difference, square and rounding-bias stages,
// one stage per bit of the 28-bit partial quotient, a sum stage, a share
// numerator stage, and one stage per bit of the 7-bit share quotient.
// Throughput is one request per cycle while the output is not stalled; every stage moves together.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the data registers need no reset.
// A zero total gives all-zero fields with degenerate 1; a zero chi-square
// sum gives zero shares with degenerate 2.
module chi_square_uniform_four_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cs4_pkg::IN_W-1:0]           count_a,
    input  logic [cs4_pkg::IN_W-1:0]           count_c,
    input  logic [cs4_pkg::IN_W-1:0]           count_g,
    input  logic [cs4_pkg::IN_W-1:0]           count_t,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cs4_pkg::OUT_TOT_W-1:0]      total_count,
    output logic [cs4_pkg::OUT_PART_W-1:0]     partial_a,
    output logic [cs4_pkg::OUT_PART_W-1:0]     partial_c,
    output logic [cs4_pkg::OUT_PART_W-1:0]     partial_g,
    output logic [cs4_pkg::OUT_PART_W-1:0]     partial_t,
    output logic [cs4_pkg::OUT_PART_W-1:0]     chi_total,
    output logic [cs4_pkg::OUT_SHARE_W-1:0]    share_a,
    output logic [cs4_pkg::OUT_SHARE_W-1:0]    share_c,
    output logic [cs4_pkg::OUT_SHARE_W-1:0]    share_g,
    output logic [cs4_pkg::OUT_SHARE_W-1:0]    share_t,
    output logic [cs4_pkg::OUT_DEG_W-1:0]      degenerate
);

    logic                              adv;
    logic                              vld_reg  [cs4_pkg::LAT];
    logic [cs4_pkg::TOTAL_W-1:0]       tot_reg  [cs4_pkg::LAT];
    logic [cs4_pkg::TOTAL_W-1:0]       tot_next;

    logic [cs4_pkg::COUNT_BITS-1:0]    cnt_in   [cs4_pkg::LANES];
    logic [cs4_pkg::COUNT_BITS-1:0]    cnt_reg  [cs4_pkg::LANES];
    logic [cs4_pkg::DIFF_W-1:0]        diff_next[cs4_pkg::LANES];
    logic [cs4_pkg::DIFF_W-1:0]        diff_reg [cs4_pkg::LANES];
    logic [cs4_pkg::SQ_W-1:0]          sq_reg   [cs4_pkg::LANES];
    logic [cs4_pkg::PDIV_W-1:0]        pdvd_reg [cs4_pkg::LANES];
    logic [cs4_pkg::PQ_W-1:0]          pq       [cs4_pkg::LANES];
    logic [cs4_pkg::PQ_W-1:0]          part_next[cs4_pkg::LANES];
    logic [cs4_pkg::SUM_W-1:0]         sum_next;
    logic [cs4_pkg::PQ_W-1:0]          part_reg [cs4_pkg::MIDD][cs4_pkg::LANES];
    logic [cs4_pkg::SUM_W-1:0]         sum_reg  [cs4_pkg::MIDD];
    logic [cs4_pkg::SN_W-1:0]          shn_reg  [cs4_pkg::LANES];
    logic [cs4_pkg::SHQ_W-1:0]         shq      [cs4_pkg::LANES];
    logic [cs4_pkg::DEN_W-1:0]         pdiv_den;
    logic [cs4_pkg::SHDEN_W-1:0]       sdiv_den;
    logic [cs4_pkg::TOTAL_W-1:0]       tot_out;
    logic [cs4_pkg::SUM_W-1:0]         sum_out;
    logic [cs4_pkg::OUT_DEG_W-1:0]     deg;

    // The pipeline moves unless a finished result is waiting at the output.
    assign adv       = !(vld_reg[cs4_pkg::LAT-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[cs4_pkg::LAT-1];

    assign cnt_in[0] = cs4_pkg::COUNT_BITS'(count_a);
    assign cnt_in[1] = cs4_pkg::COUNT_BITS'(count_c);
    assign cnt_in[2] = cs4_pkg::COUNT_BITS'(count_g);
    assign cnt_in[3] = cs4_pkg::COUNT_BITS'(count_t);

    assign tot_next = cs4_pkg::TOTAL_W'(cnt_in[0]) + cs4_pkg::TOTAL_W'(cnt_in[1])
                    + cs4_pkg::TOTAL_W'(cnt_in[2]) + cs4_pkg::TOTAL_W'(cnt_in[3]);

    always_comb
    begin
        logic [cs4_pkg::TOTAL_W-1:0] x4;
        sum_next = '0;
        for (int i = 0; i < cs4_pkg::LANES; i++)
        begin
            x4 = {cnt_reg[i], 2'b00};
            diff_next[i] = (x4 >= tot_reg[0]) ? (x4 - tot_reg[0]) : (tot_reg[0] - x4);
            part_next[i] = (tot_reg[cs4_pkg::M1-1] == '0) ? '0 : pq[i];
            sum_next     = sum_next + cs4_pkg::SUM_W'(part_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < cs4_pkg::LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < cs4_pkg::LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tot_reg[0] <= tot_next;
            for (int k = 1; k < cs4_pkg::LAT; k++)
            begin
                tot_reg[k] <= tot_reg[k-1];
            end
            for (int i = 0; i < cs4_pkg::LANES; i++)
            begin
                cnt_reg[i]  <= cnt_in[i];
                diff_reg[i] <= diff_next[i];
                sq_reg[i]   <= cs4_pkg::SQ_W'(diff_reg[i]) * cs4_pkg::SQ_W'(diff_reg[i]);
                // Adding half the divisor (2T) rounds the quotient to nearest.
                pdvd_reg[i] <= (cs4_pkg::PDIV_W'(sq_reg[i]) << cs4_pkg::FRAC_BITS)
                             + cs4_pkg::PDIV_W'({tot_reg[2], 1'b0});
                part_reg[0][i] <= part_next[i];
                shn_reg[i] <= cs4_pkg::SN_W'(part_reg[0][i])
                            * cs4_pkg::SN_W'(cs4_pkg::SHARE_SCALE)
                            + cs4_pkg::SN_W'(sum_reg[0]);
            end
            sum_reg[0] <= sum_next;
            for (int k = 1; k < cs4_pkg::MIDD; k++)
            begin
                part_reg[k] <= part_reg[k-1];
                sum_reg[k]  <= sum_reg[k-1];
            end
        end
    end

    assign pdiv_den = {tot_reg[3], 2'b00};
    assign sdiv_den = {sum_reg[1], 1'b0};

    for (genvar i = 0; i < cs4_pkg::LANES; i++)
    begin : g_lane
        cs4_part_div u_pdiv (
            .clk      (clk),
            .en       (adv),
            .dividend (pdvd_reg[i]),
            .divisor  (pdiv_den),
            .quotient (pq[i])
        );

        cs4_share_div u_sdiv (
            .clk      (clk),
            .en       (adv),
            .dividend (shn_reg[i]),
            .divisor  (sdiv_den),
            .quotient (shq[i])
        );
    end

    assign tot_out = tot_reg[cs4_pkg::LAT-1];
    assign sum_out = sum_reg[cs4_pkg::MIDD-1];

    always_comb
    begin
        if (tot_out == '0)
        begin
            deg = cs4_pkg::DEG_ZERO_TOTAL;
        end
        else if (sum_out == '0)
        begin
            deg = cs4_pkg::DEG_ZERO_CHI;
        end
        else
        begin
            deg = cs4_pkg::DEG_NONE;
        end
    end

    assign degenerate  = deg;
    assign total_count = cs4_pkg::OUT_TOT_W'(tot_out);
    assign chi_total   = cs4_pkg::OUT_PART_W'(sum_out);
    assign partial_a   = cs4_pkg::OUT_PART_W'(part_reg[cs4_pkg::MIDD-1][0]);
    assign partial_c   = cs4_pkg::OUT_PART_W'(part_reg[cs4_pkg::MIDD-1][1]);
    assign partial_g   = cs4_pkg::OUT_PART_W'(part_reg[cs4_pkg::MIDD-1][2]);
    assign partial_t   = cs4_pkg::OUT_PART_W'(part_reg[cs4_pkg::MIDD-1][3]);
    // The share divider sees a zero divisor in both degenerate cases.
    assign share_a = (deg == cs4_pkg::DEG_NONE) ? cs4_pkg::OUT_SHARE_W'(shq[0]) : '0;
    assign share_c = (deg == cs4_pkg::DEG_NONE) ? cs4_pkg::OUT_SHARE_W'(shq[1]) : '0;
    assign share_g = (deg == cs4_pkg::DEG_NONE) ? cs4_pkg::OUT_SHARE_W'(shq[2]) : '0;
    assign share_t = (deg == cs4_pkg::DEG_NONE) ? cs4_pkg::OUT_SHARE_W'(shq[3]) : '0;

endmodule

### rtl/cs4_checker.sv
// Port-level checks for chi_square_uniform_four_core, bound to the top level.
// Depends on cs4_pkg for field widths and flag codes.
module cs4_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [cs4_pkg::OUT_TOT_W-1:0]      total_count,
    input  logic [cs4_pkg::OUT_PART_W-1:0]     chi_total,
    input  logic [cs4_pkg::OUT_SHARE_W-1:0]    share_a,
    input  logic [cs4_pkg::OUT_DEG_W-1:0]      degenerate
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chi_total) && $stable(total_count))
        else $error("result changed while stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a waiting result");

    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate == cs4_pkg::DEG_ZERO_TOTAL |->
            total_count == '0 && chi_total == '0 && share_a == '0)
        else $error("zero-total result not cleared");

    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate == cs4_pkg::DEG_NONE |-> chi_total != '0 && total_count != '0)
        else $error("normal result with zero sum");

    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> share_a <= cs4_pkg::OUT_SHARE_W'(100))
        else $error("share above one hundred percent");

endmodule

bind chi_square_uniform_four_core cs4_checker u_cs4_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .total_count (total_count),
    .chi_total   (chi_total),
    .share_a     (share_a),
    .degenerate  (degenerate)
);
